// File: rtl/gcrnd_pkg.sv
`timescale 1ns / 1ps

package gcrnd_pkg;

   localparam int CODE_W     = 10;
   localparam int HALF_W     = 5;
   localparam int CONF_W     = 8;
   localparam int NIB_W      = 4;
   localparam int NUM_CAND   = 16;
   localparam int IDX_W      = $clog2(NUM_CAND);
   localparam int GROUPS     = 4;
   localparam int GROUP_SIZE = NUM_CAND / GROUPS;
   localparam int GIDX_W     = $clog2(GROUPS);
   // worst cost sum is five bits at full doubt: 5 * 255
   localparam int SUM_W      = 11;
   localparam int DIST_W     = 3;
   localparam int CORR_W     = 2;
   localparam int CONF25_W   = 6;
   localparam int FACTOR_W   = 4;
   localparam int PIPE_DEPTH = 4;

   // distance given to a half with no candidate closer than the start value
   localparam logic [DIST_W-1:0] DIST_NONE = 3'd6;
   localparam logic [NIB_W-1:0]  NIB_NONE  = 4'h0;

   // valid codes in ascending order, and their nibbles
   localparam logic [HALF_W-1:0] CAND_CODE [NUM_CAND] = '{
      5'd9,  5'd10, 5'd11, 5'd13, 5'd14, 5'd15, 5'd18, 5'd19,
      5'd21, 5'd22, 5'd23, 5'd25, 5'd26, 5'd27, 5'd29, 5'd30
   };
   localparam logic [NIB_W-1:0] CAND_NIB [NUM_CAND] = '{
      4'h8, 4'h0, 4'h1, 4'hC, 4'h4, 4'h5, 4'h2, 4'h3,
      4'hF, 4'h6, 4'h7, 4'h9, 4'hA, 4'hB, 4'hD, 4'hE
   };

   // soft distance d >= k exactly when the cost sum reaches 51k - 25
   localparam int NUM_STEP = 6;
   localparam logic [SUM_W-1:0] SOFT_STEP [NUM_STEP] = '{
      11'd26, 11'd77, 11'd128, 11'd179, 11'd230, 11'd281
   };

   typedef struct packed {
      logic                               direct;
      logic [NIB_W-1:0]                   direct_nib;
      logic [GROUPS-1:0][DIST_W-1:0]      grp_dist;
      logic [GROUPS-1:0][IDX_W-1:0]       idx;
   } half_pick_type;

endpackage

// File: rtl/gcrnd_req_if.sv
`timescale 1ns / 1ps

interface gcrnd_req_if;
   logic       valid;
   logic       ready;
   logic [9:0] code_bits;
   logic [7:0] conf_bit0;
   logic [7:0] conf_bit1;
   logic [7:0] conf_bit2;
   logic [7:0] conf_bit3;
   logic [7:0] conf_bit4;
   logic [7:0] conf_bit5;
   logic [7:0] conf_bit6;
   logic [7:0] conf_bit7;
   logic [7:0] conf_bit8;
   logic [7:0] conf_bit9;

   modport source (
      output valid, code_bits, conf_bit0, conf_bit1, conf_bit2, conf_bit3, conf_bit4,
             conf_bit5, conf_bit6, conf_bit7, conf_bit8, conf_bit9,
      input  ready
   );
   modport sink (
      input  valid, code_bits, conf_bit0, conf_bit1, conf_bit2, conf_bit3, conf_bit4,
             conf_bit5, conf_bit6, conf_bit7, conf_bit8, conf_bit9,
      output ready
   );
endinterface

// File: rtl/gcrnd_rsp_if.sv
`timescale 1ns / 1ps

interface gcrnd_rsp_if;
   logic              valid;
   logic              ready;
   logic [7:0]        data_byte;
   logic [1:0]        correction_count;
   logic signed [5:0] confidence_x25;

   modport source (
      output valid, data_byte, correction_count, confidence_x25,
      input  ready
   );
   modport sink (
      input  valid, data_byte, correction_count, confidence_x25,
      output ready
   );
endinterface

// File: rtl/gcrnd_half_search.sv
`timescale 1ns / 1ps

module gcrnd_half_search (
   input  logic                                                 clock,
   input  logic                                                 advance,
   input  logic                                                 soft_en,
   input  logic [gcrnd_pkg::HALF_W-1:0]                         rx,
   input  logic [gcrnd_pkg::HALF_W-1:0][gcrnd_pkg::CONF_W-1:0]  conf,
   output gcrnd_pkg::half_pick_type                             pick
);

   localparam int NC = gcrnd_pkg::NUM_CAND;
   localparam int SW = gcrnd_pkg::SUM_W;
   localparam int DW = gcrnd_pkg::DIST_W;
   localparam int IW = gcrnd_pkg::IDX_W;

   function automatic logic [DW-1:0] soft_dist(input logic [SW-1:0] s);
      logic [DW-1:0] d;
      d = '0;
      for (int k = 0; k < gcrnd_pkg::NUM_STEP; k++) begin
         if (s >= gcrnd_pkg::SOFT_STEP[k]) begin
            d = d + DW'(1);
         end
      end
      return d;
   endfunction

   // lower index wins a tie
   function automatic logic [DW+IW-1:0] pick2(input logic [DW+IW-1:0] a,
                                              input logic [DW+IW-1:0] b);
      logic [DW+IW-1:0] r;
      r = (b[DW+IW-1:IW] < a[DW+IW-1:IW]) ? b : a;
      return r;
   endfunction

   // stage A: cost sum and mismatch count per candidate
   logic [NC-1:0][gcrnd_pkg::HALF_W-1:0] diff_a;
   logic [NC-1:0][SW-1:0]                sum_in,  sum_ff;
   logic [NC-1:0][DW-1:0]                ham_in,  ham_ff;
   logic                                 direct_a_in, direct_a_ff;
   logic [gcrnd_pkg::NIB_W-1:0]          nib_a_in,    nib_a_ff;

   always_comb begin
      direct_a_in = 1'b0;
      nib_a_in    = gcrnd_pkg::NIB_NONE;
      for (int j = 0; j < NC; j++) begin
         diff_a[j] = rx ^ gcrnd_pkg::CAND_CODE[j];
         sum_in[j] = '0;
         ham_in[j] = '0;
         for (int p = 0; p < gcrnd_pkg::HALF_W; p++) begin
            if (diff_a[j][p]) begin
               sum_in[j] = sum_in[j] + {{(SW-gcrnd_pkg::CONF_W){1'b0}}, ~conf[p]};
               ham_in[j] = ham_in[j] + DW'(1);
            end
         end
         if (rx == gcrnd_pkg::CAND_CODE[j]) begin
            direct_a_in = 1'b1;
            nib_a_in    = gcrnd_pkg::CAND_NIB[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff      <= sum_in;
         ham_ff      <= ham_in;
         direct_a_ff <= direct_a_in;
         nib_a_ff    <= nib_a_in;
      end
   end

   // stage B: distance, saturated at the start value
   logic [NC-1:0][DW-1:0]       dist_in, dist_ff;
   logic                        direct_b_ff;
   logic [gcrnd_pkg::NIB_W-1:0] nib_b_ff;

   always_comb begin
      for (int j = 0; j < NC; j++) begin
         dist_in[j] = soft_en ? soft_dist(sum_ff[j]) : ham_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dist_ff     <= dist_in;
         direct_b_ff <= direct_a_ff;
         nib_b_ff    <= nib_a_ff;
      end
   end

   // stage C: best of each group of four
   gcrnd_pkg::half_pick_type pick_in, pick_ff;
   logic [gcrnd_pkg::GROUPS-1:0][DW+IW-1:0] lo_c, hi_c, best_c;

   always_comb begin
      pick_in.direct     = direct_b_ff;
      pick_in.direct_nib = nib_b_ff;
      for (int g = 0; g < gcrnd_pkg::GROUPS; g++) begin
         lo_c[g]   = pick2({dist_ff[4*g],   IW'(4*g)},   {dist_ff[4*g+1], IW'(4*g+1)});
         hi_c[g]   = pick2({dist_ff[4*g+2], IW'(4*g+2)}, {dist_ff[4*g+3], IW'(4*g+3)});
         best_c[g] = pick2(lo_c[g], hi_c[g]);
         pick_in.grp_dist[g] = best_c[g][DW+IW-1:IW];
         pick_in.idx[g]      = best_c[g][IW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pick_ff <= pick_in;
      end
   end

   assign pick = pick_ff;

endmodule

// File: rtl/gcr_soft_nearest_code_decode_core.sv
`timescale 1ns / 1ps

// Each accepted request beat passes through stages A, B, C and the output register to its response beat.
// Throughput: one beat per cycle; the four stages share one advance, so
// a stalled response holds the whole pipe and req_chan.ready follows it.
// Reset (synchronous) clears the stage valid bits and soft_ff.
module gcr_soft_nearest_code_decode_core (
   input  logic clock,
   input  logic reset,
   gcrnd_req_if.sink   req_chan,
   gcrnd_rsp_if.source rsp_chan,
   input  logic csr_wr_en,
   input  logic csr_wr_data
);

   localparam int DW = gcrnd_pkg::DIST_W;
   localparam int IW = gcrnd_pkg::IDX_W;
   localparam int NW = gcrnd_pkg::NIB_W;
   localparam int FW = gcrnd_pkg::FACTOR_W;

   logic soft_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         soft_ff <= 1'b0;
      end else if (csr_wr_en) begin
         soft_ff <= csr_wr_data;
      end
   end

   logic [gcrnd_pkg::PIPE_DEPTH-1:0] valid_in, valid_ff;
   logic advance;

   assign advance        = !valid_ff[gcrnd_pkg::PIPE_DEPTH-1] || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign valid_in = {valid_ff[gcrnd_pkg::PIPE_DEPTH-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   logic [gcrnd_pkg::HALF_W-1:0][gcrnd_pkg::CONF_W-1:0] conf_hi, conf_lo;
   gcrnd_pkg::half_pick_type pick_hi, pick_lo;

   // first received bit is the msb of each half
   assign conf_hi = {req_chan.conf_bit0, req_chan.conf_bit1, req_chan.conf_bit2,
                     req_chan.conf_bit3, req_chan.conf_bit4};
   assign conf_lo = {req_chan.conf_bit5, req_chan.conf_bit6, req_chan.conf_bit7,
                     req_chan.conf_bit8, req_chan.conf_bit9};

   gcrnd_half_search u_hi (
      .clock   (clock),
      .advance (advance),
      .soft_en (soft_ff),
      .rx      (req_chan.code_bits[9:5]),
      .conf    (conf_hi),
      .pick    (pick_hi)
   );

   gcrnd_half_search u_lo (
      .clock   (clock),
      .advance (advance),
      .soft_en (soft_ff),
      .rx      (req_chan.code_bits[4:0]),
      .conf    (conf_lo),
      .pick    (pick_lo)
   );

   function automatic logic [DW+IW-1:0] pick2(input logic [DW+IW-1:0] a,
                                              input logic [DW+IW-1:0] b);
      logic [DW+IW-1:0] r;
      r = (b[DW+IW-1:IW] < a[DW+IW-1:IW]) ? b : a;
      return r;
   endfunction

   // final choice for one half: {corrected, dist, nibble}
   function automatic logic [DW+NW:0] resolve(input gcrnd_pkg::half_pick_type p);
      logic [DW+IW-1:0] l, h, b;
      logic [DW+NW:0]   r;
      l = pick2({p.grp_dist[0], p.idx[0]}, {p.grp_dist[1], p.idx[1]});
      h = pick2({p.grp_dist[2], p.idx[2]}, {p.grp_dist[3], p.idx[3]});
      b = pick2(l, h);
      if (p.direct) begin
         r = {1'b0, DW'(0), p.direct_nib};
      end else if (b[DW+IW-1:IW] < gcrnd_pkg::DIST_NONE) begin
         r = {1'b1, b[DW+IW-1:IW], gcrnd_pkg::CAND_NIB[b[IW-1:0]]};
      end else begin
         r = {1'b1, gcrnd_pkg::DIST_NONE, gcrnd_pkg::NIB_NONE};
      end
      return r;
   endfunction

   logic [DW+NW:0]        res_hi, res_lo;
   logic signed [FW-1:0]  fac_hi, fac_lo;
   logic signed [2*FW-1:0] prod;

   logic [7:0]                           byte_in, byte_ff;
   logic [gcrnd_pkg::CORR_W-1:0]         corr_in, corr_ff;
   logic signed [gcrnd_pkg::CONF25_W-1:0] c25_in, c25_ff;

   always_comb begin
      res_hi  = resolve(pick_hi);
      res_lo  = resolve(pick_lo);
      fac_hi  = FW'(5) - signed'({1'b0, res_hi[DW+NW-1:NW]});
      fac_lo  = FW'(5) - signed'({1'b0, res_lo[DW+NW-1:NW]});
      prod    = fac_hi * fac_lo;
      byte_in = {res_hi[NW-1:0], res_lo[NW-1:0]};
      corr_in = gcrnd_pkg::CORR_W'(res_hi[DW+NW]) + gcrnd_pkg::CORR_W'(res_lo[DW+NW]);
      c25_in  = prod[gcrnd_pkg::CONF25_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= byte_in;
         corr_ff <= corr_in;
         c25_ff  <= c25_in;
      end
   end

   assign rsp_chan.valid            = valid_ff[gcrnd_pkg::PIPE_DEPTH-1];
   assign rsp_chan.data_byte        = byte_ff;
   assign rsp_chan.correction_count = corr_ff;
   assign rsp_chan.confidence_x25   = c25_ff;

endmodule
